FILE: rtl/spdq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spdq_pkg: shared types and constants of the switch press duration qualifier
// Press type codes, status codes, register indexes, field widths and defaults.
// ----------------------------------------------------------------------------
package spdq_pkg;

   // Switch map slots held by the pin and type maps
   localparam int MapSlots     = 8;
   localparam int PinNumWidth  = 5;
   localparam int KindWidth    = 3;
   localparam int IndexWidth   = 3;
   localparam int PinsWidth    = 32;
   localparam int LevelsWidth  = 8;
   localparam int TicksWidth   = 16;
   localparam int CsrIdxWidth  = 3;
   localparam int CsrDataWidth = 40;

   localparam int DefaultNumSwitches = 8;
   localparam int DefaultTimeWidth   = 32;

   // Register reset values
   localparam logic [PinsWidth-1:0]              ValidPinMaskRst   = '1;
   localparam logic [MapSlots*PinNumWidth-1:0]   SwitchPinMapRst   = '0;
   localparam logic [MapSlots*KindWidth-1:0]     SwitchTypeMapRst  = '0;
   localparam logic [TicksWidth-1:0]             NormalMinTicksRst = 16'd5;
   localparam logic [TicksWidth-1:0]             NormalMaxTicksRst = 16'd100;
   localparam logic [TicksWidth-1:0]             EdgeMinTicksRst   = 16'd5;

   typedef enum logic [KindWidth-1:0] {
      KIND_NONE      = 3'd0,
      KIND_NORMAL    = 3'd1,
      KIND_LONG      = 3'd2,
      KIND_EDGE_LONG = 3'd3,
      KIND_EDGE      = 3'd4
   } press_kind_type;

   typedef enum logic [1:0] {
      STATUS_NONE     = 2'd0,
      STATUS_PRESS    = 2'd1,
      STATUS_NO_MATCH = 2'd2
   } status_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_VALID_PIN_MASK   = 3'd0,
      CSR_SWITCH_PIN_MAP   = 3'd1,
      CSR_SWITCH_TYPE_MAP  = 3'd2,
      CSR_NORMAL_MIN_TICKS = 3'd3,
      CSR_NORMAL_MAX_TICKS = 3'd4,
      CSR_EDGE_MIN_TICKS   = 3'd5
   } csr_index_type;

   // Item kind carried on the request tuser
   localparam logic MODE_TICK      = 1'b0;
   localparam logic MODE_INTERRUPT = 1'b1;

endpackage : spdq_pkg
`default_nettype wire

FILE: rtl/switch_press_duration_qualifier_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// switch_press_duration_qualifier_unit: membrane switch press qualifier
// Qualifies switch presses by duration from tick and pin interrupt items.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  stream input. tuser is the item kind (tick or pin interrupt),
//          tdata carries the interrupting pins and the switch level sample.
//   rsp_*  stream output, exactly one transfer per accepted input item.
//          tuser is the status, tdata the switch index and press kind.
//   csr_*  register write channel, always ready. Write only while idle.
// Pipeline: the accept edge reads the start-time memory and loads the execute
//   stage; the execute stage then executes the item and registers the result
//   in the result register (see Stall).
// Throughput: one item per cycle while rsp_tready is high. The start-time memory
//   is read on the accept edge and written on the execute edge; a write to the
//   entry the next item just read is forwarded from a bypass register.
// Reset: time counter, pending bits and tracker clear, registers take their
//   defaults; start-time memory is not cleared (an entry is only read while
//   its pending bit is set, which implies it was written).
// Stall: while rsp_tready is low the result register holds, the execute stage
//   holds its item, and req_tready drops while the execute stage holds an
//   item that cannot advance.
// ----------------------------------------------------------------------------
module switch_press_duration_qualifier_unit #(
   parameter int NUM_SWITCHES = spdq_pkg::DefaultNumSwitches,
   parameter int TIME_WIDTH   = spdq_pkg::DefaultTimeWidth
) (
   input  wire logic clock,
   input  wire logic reset,
   // request stream
   input  wire logic req_tvalid,
   output logic req_tready,
   input  wire logic [39:0] req_tdata, // [31:0] pins, [39:32] switch_levels
   input  wire logic req_tuser,        // [0] mode
   // result stream
   output logic rsp_tvalid,
   input  wire logic rsp_tready,
   output logic [7:0] rsp_tdata,       // [2:0] switch_index, [5:3] press_kind, [7:6] zero
   output logic [1:0] rsp_tuser,       // [1:0] status
   // register writes
   input  wire logic csr_valid,
   output logic csr_ready,
   input  wire logic [spdq_pkg::CsrIdxWidth-1:0] csr_index,
   input  wire logic [spdq_pkg::CsrDataWidth-1:0] csr_data
);

   // Only the first eight switches can be described by the maps
   localparam int ActiveCount = (NUM_SWITCHES > spdq_pkg::MapSlots) ?
                                spdq_pkg::MapSlots : NUM_SWITCHES;
   localparam int AddrW       = (ActiveCount > 1) ? $clog2(ActiveCount) : 1;
   localparam int PinW        = spdq_pkg::PinNumWidth;
   localparam int KindW       = spdq_pkg::KindWidth;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [spdq_pkg::PinsWidth-1:0]                 valid_pin_mask_ff;
   logic [spdq_pkg::MapSlots*PinW-1:0]             switch_pin_map_ff;
   logic [spdq_pkg::MapSlots*KindW-1:0]            switch_type_map_ff;
   logic [spdq_pkg::TicksWidth-1:0]                normal_min_ticks_ff;
   logic [spdq_pkg::TicksWidth-1:0]                normal_max_ticks_ff;
   logic [spdq_pkg::TicksWidth-1:0]                edge_min_ticks_ff;

   assign csr_ready = 1'b1;

   // Take every transfer; an index past the register list is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_pin_mask_ff   <= spdq_pkg::ValidPinMaskRst;
         switch_pin_map_ff   <= spdq_pkg::SwitchPinMapRst;
         switch_type_map_ff  <= spdq_pkg::SwitchTypeMapRst;
         normal_min_ticks_ff <= spdq_pkg::NormalMinTicksRst;
         normal_max_ticks_ff <= spdq_pkg::NormalMaxTicksRst;
         edge_min_ticks_ff   <= spdq_pkg::EdgeMinTicksRst;
      end else if (csr_valid && csr_ready) begin
         case (spdq_pkg::csr_index_type'(csr_index))
            spdq_pkg::CSR_VALID_PIN_MASK: begin
               valid_pin_mask_ff <= csr_data[spdq_pkg::PinsWidth-1:0];
            end
            spdq_pkg::CSR_SWITCH_PIN_MAP: begin
               switch_pin_map_ff <= csr_data[spdq_pkg::MapSlots*PinW-1:0];
            end
            spdq_pkg::CSR_SWITCH_TYPE_MAP: begin
               switch_type_map_ff <= csr_data[spdq_pkg::MapSlots*KindW-1:0];
            end
            spdq_pkg::CSR_NORMAL_MIN_TICKS: begin
               normal_min_ticks_ff <= csr_data[spdq_pkg::TicksWidth-1:0];
            end
            spdq_pkg::CSR_NORMAL_MAX_TICKS: begin
               normal_max_ticks_ff <= csr_data[spdq_pkg::TicksWidth-1:0];
            end
            spdq_pkg::CSR_EDGE_MIN_TICKS: begin
               edge_min_ticks_ff <= csr_data[spdq_pkg::TicksWidth-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Lookup stage: mask the pins and find the first matching switch
   // ------------------------------------------------------------------
   logic                              req_xfer;
   logic [spdq_pkg::PinsWidth-1:0]    masked_pins;
   logic                              lookup_hit;
   logic [AddrW-1:0]                  lookup_idx;

   assign req_xfer    = req_tvalid && req_tready;
   assign masked_pins = req_tdata[spdq_pkg::PinsWidth-1:0] & valid_pin_mask_ff;

   // Priority search: the lowest switch whose one-hot pin equals the mask wins
   always_comb begin
      lookup_hit = 1'b0;
      lookup_idx = '0;
      for (int i = 0; i < ActiveCount; i++) begin
         if (!lookup_hit &&
             (masked_pins == (spdq_pkg::PinsWidth'(1) << switch_pin_map_ff[i*PinW +: PinW])))
         begin
            lookup_hit = 1'b1;
            lookup_idx = AddrW'(i);
         end
      end
   end

   // ------------------------------------------------------------------
   // Start-time memory, read on accept, written on execute
   // ------------------------------------------------------------------
   logic [TIME_WIDTH-1:0]  start_mem [ActiveCount];
   logic [TIME_WIDTH-1:0]  start_rd_ff;
   logic                   mem_we;
   logic [AddrW-1:0]       mem_waddr;
   logic [TIME_WIDTH-1:0]  mem_wdata;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         start_mem[mem_waddr] <= mem_wdata;
      end
      if (req_xfer) begin
         start_rd_ff <= start_mem[lookup_idx];
      end
   end

   // ------------------------------------------------------------------
   // Execute stage registers
   // ------------------------------------------------------------------
   logic                              ex_valid_ff, ex_valid_in;
   logic                              ex_mode_ff;
   logic [spdq_pkg::LevelsWidth-1:0]  ex_levels_ff;
   logic                              ex_hit_ff;
   logic [AddrW-1:0]                  ex_idx_ff;

   // Bypass of the last memory write, for an item read on the same edge
   logic                              fwd_valid_ff;
   logic [AddrW-1:0]                  fwd_idx_ff;
   logic [TIME_WIDTH-1:0]             fwd_data_ff;

   // Block state kept in flops
   logic [TIME_WIDTH-1:0]             time_now_ff, time_now_in;
   logic [ActiveCount-1:0]            pending_ff, pending_in;
   logic                              trk_busy_ff, trk_busy_in;
   logic [AddrW-1:0]                  trk_idx_ff, trk_idx_in;
   logic [TIME_WIDTH-1:0]             trk_start_ff, trk_start_in;

   // Result register
   logic                              rsp_valid_ff, rsp_valid_in;
   spdq_pkg::status_type              rsp_status_ff, rsp_status_in;
   logic [spdq_pkg::IndexWidth-1:0]   rsp_idx_ff, rsp_idx_in;
   logic [KindW-1:0]                  rsp_kind_ff, rsp_kind_in;

   logic                              ex_commit;
   logic [TIME_WIDTH-1:0]             start_eff;
   logic [TIME_WIDTH-1:0]             time_tick;
   logic [TIME_WIDTH-1:0]             trk_elapsed;
   logic [TIME_WIDTH-1:0]             press_elapsed;
   logic [KindW-1:0]                  ex_kind;
   logic [KindW-1:0]                  trk_kind;

   // Advance the execute stage when the result register is free or draining
   assign ex_commit  = ex_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !ex_valid_ff || ex_commit;

   assign start_eff     = (fwd_valid_ff && (fwd_idx_ff == ex_idx_ff)) ? fwd_data_ff
                                                                       : start_rd_ff;
   assign time_tick     = time_now_ff + TIME_WIDTH'(1);
   assign trk_elapsed   = time_tick - trk_start_ff;
   assign press_elapsed = time_now_ff - start_eff;
   assign ex_kind       = switch_type_map_ff[KindW*int'(ex_idx_ff) +: KindW];
   assign trk_kind      = switch_type_map_ff[KindW*int'(trk_idx_ff) +: KindW];

   always_comb begin
      ex_valid_in   = ex_valid_ff;
      time_now_in   = time_now_ff;
      pending_in    = pending_ff;
      trk_busy_in   = trk_busy_ff;
      trk_idx_in    = trk_idx_ff;
      trk_start_in  = trk_start_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = spdq_pkg::STATUS_NONE;
      rsp_idx_in    = '0;
      rsp_kind_in   = '0;
      mem_we        = 1'b0;
      mem_waddr     = ex_idx_ff;
      mem_wdata     = time_now_ff;

      // Drop the result once it has been taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (ex_commit) begin
         rsp_valid_in = 1'b1;
         ex_valid_in  = 1'b0;
         if (ex_mode_ff == spdq_pkg::MODE_TICK) begin
            time_now_in = time_tick;
            if (trk_busy_ff) begin
               if (trk_elapsed > TIME_WIDTH'(edge_min_ticks_ff)) begin
                  // Held long enough: report the tracked switch
                  rsp_status_in = spdq_pkg::STATUS_PRESS;
                  rsp_idx_in    = spdq_pkg::IndexWidth'(trk_idx_ff);
                  rsp_kind_in   = trk_kind;
                  trk_busy_in   = 1'b0;
               end else if (!ex_levels_ff[trk_idx_ff]) begin
                  // Released early: stop silently
                  trk_busy_in = 1'b0;
               end
            end
         end else if (!ex_hit_ff) begin
            rsp_status_in = spdq_pkg::STATUS_NO_MATCH;
         end else begin
            case (spdq_pkg::press_kind_type'(ex_kind))
               spdq_pkg::KIND_NORMAL: begin
                  if (!pending_ff[ex_idx_ff]) begin
                     // First interrupt: open an attempt at the current time
                     pending_in[ex_idx_ff] = 1'b1;
                     mem_we                = 1'b1;
                  end else if (press_elapsed > TIME_WIDTH'(normal_max_ticks_ff)) begin
                     pending_in[ex_idx_ff] = 1'b0;
                  end else if (press_elapsed > TIME_WIDTH'(normal_min_ticks_ff)) begin
                     pending_in[ex_idx_ff] = 1'b0;
                     rsp_status_in         = spdq_pkg::STATUS_PRESS;
                     rsp_idx_in            = spdq_pkg::IndexWidth'(ex_idx_ff);
                     rsp_kind_in           = ex_kind;
                  end
               end
               spdq_pkg::KIND_EDGE_LONG,
               spdq_pkg::KIND_EDGE: begin
                  // Restart the tracker on this switch
                  trk_busy_in  = 1'b1;
                  trk_idx_in   = ex_idx_ff;
                  trk_start_in = time_now_ff;
               end
               default: begin
               end
            endcase
         end
      end

      if (req_xfer) begin
         ex_valid_in = 1'b1;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff   <= 1'b0;
         time_now_ff   <= '0;
         pending_ff    <= '0;
         trk_busy_ff   <= 1'b0;
         trk_idx_ff    <= '0;
         trk_start_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
         fwd_valid_ff  <= 1'b0;
      end else begin
         ex_valid_ff   <= ex_valid_in;
         time_now_ff   <= time_now_in;
         pending_ff    <= pending_in;
         trk_busy_ff   <= trk_busy_in;
         trk_idx_ff    <= trk_idx_in;
         trk_start_ff  <= trk_start_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (ex_commit) begin
            fwd_valid_ff <= mem_we;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         ex_mode_ff   <= req_tuser;
         ex_levels_ff <= req_tdata[39:32];
         ex_hit_ff    <= lookup_hit;
         ex_idx_ff    <= lookup_idx;
      end
      if (ex_commit) begin
         fwd_idx_ff    <= mem_waddr;
         fwd_data_ff   <= mem_wdata;
         rsp_status_ff <= rsp_status_in;
         rsp_idx_ff    <= rsp_idx_in;
         rsp_kind_ff   <= rsp_kind_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {2'b00, rsp_kind_ff, rsp_idx_ff};

`ifndef SYNTHESIS
   // A result that is not a press carries no switch and no kind
   a_idle_payload_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != spdq_pkg::STATUS_PRESS)) |->
      (rsp_idx_ff == '0 && rsp_kind_ff == '0))
      else $error("non-press result carries a switch or kind");

   // A committed tick advances the time counter by exactly one
   a_tick_advance: assert property (@(posedge clock) disable iff (reset)
      (ex_commit && ex_mode_ff == spdq_pkg::MODE_TICK) |=>
      (time_now_ff == $past(time_now_ff) + TIME_WIDTH'(1)))
      else $error("tick did not advance time");

   // Time holds unless an item executes
   a_time_hold: assert property (@(posedge clock) disable iff (reset)
      !ex_commit |=> $stable(time_now_ff))
      else $error("time changed without an executed item");

   // A stalled execute stage blocks new input
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (ex_valid_ff && rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("input accepted while execute stage stalled");
`endif

endmodule : switch_press_duration_qualifier_unit
`default_nettype wire
